// File: rtl/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit.
`timescale 1ns / 1ps

package cau_pkg;

    localparam int CAU_WORD_BITS     = 32;
    localparam int CAU_FRACTION_BITS = 16;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_MAG = 3'd4,
        CMD_NEG = 3'd5,
        CMD_INC = 3'd6,
        CMD_DEC = 3'd7
    } cmd_t;

    // per-request control travelling alongside the datapath lanes
    typedef struct packed {
        logic valid;
        cmd_t cmd;
        logic re_neg;
        logic im_neg;
        logic zdiv;
        logic ovf_re;
        logic ovf_im;
    } ctrl_t;

endpackage

// File: rtl/complex_arithmetic_unit.sv
// Top level: front pipeline, divide / square-root cell chain, clamp and output register.
// done follows the request through the stages in order:
//   four front stages, one cell per quotient / root bit, one output register.
// Throughput: one request per cycle; busy is never raised, the pipeline has no stalls.
// Results cannot be held off by the receiver; done pulses for one cycle per request.
// Reset clears the valid flags and the cell control words; data registers are left as they are.
`timescale 1ns / 1ps

module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int WORD_BITS     = CAU_WORD_BITS,
    parameter int FRACTION_BITS = CAU_FRACTION_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  command,
    input  logic signed [WORD_BITS-1:0] first_real,
    input  logic signed [WORD_BITS-1:0] first_imag,
    input  logic signed [WORD_BITS-1:0] second_real,
    input  logic signed [WORD_BITS-1:0] second_imag,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] result_real,
    output logic signed [WORD_BITS-1:0] result_imag,
    output logic                        zero_divisor,
    output logic                        saturated
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRACTION_BITS;
    localparam int RW  = 3 * W + 2;
    localparam int DW  = 2 * W + 1;
    localparam int LAT = W + 5;
    localparam logic [RW-1:0] HALF = RW'(1) << (W - 1);

    ctrl_t         chain_ctrl   [0:W];
    logic [RW-1:0] chain_rem_re [0:W];
    logic [RW-1:0] chain_rem_im [0:W];
    logic [DW-1:0] chain_den    [0:W];
    logic [W-1:0]  chain_q_re   [0:W];
    logic [W-1:0]  chain_q_im   [0:W];

    cau_front #(
        .WORD_BITS     (W),
        .FRACTION_BITS (F)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .command     (command),
        .first_real  (first_real),
        .first_imag  (first_imag),
        .second_real (second_real),
        .second_imag (second_imag),
        .ctrl        (chain_ctrl[0]),
        .rem_re      (chain_rem_re[0]),
        .rem_im      (chain_rem_im[0]),
        .den         (chain_den[0])
    );

    assign chain_q_re[0] = '0;
    assign chain_q_im[0] = '0;

    // most significant bit first
    for (genvar i = 0; i < W; i++)
    begin : g_cell
        cau_cell #(
            .WORD_BITS (W),
            .STEP      (W - 1 - i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_i   (chain_ctrl[i]),
            .rem_re_i (chain_rem_re[i]),
            .rem_im_i (chain_rem_im[i]),
            .den_i    (chain_den[i]),
            .q_re_i   (chain_q_re[i]),
            .q_im_i   (chain_q_im[i]),
            .ctrl_o   (chain_ctrl[i+1]),
            .rem_re_o (chain_rem_re[i+1]),
            .rem_im_o (chain_rem_im[i+1]),
            .den_o    (chain_den[i+1]),
            .q_re_o   (chain_q_re[i+1]),
            .q_im_o   (chain_q_im[i+1])
        );
    end

    ctrl_t         tail;
    logic [RW-1:0] mag_re, mag_im;
    logic          sat_re, sat_im;
    logic [W-1:0]  val_re, val_im;

    logic          done_reg;
    logic [W-1:0]  result_real_reg, result_imag_reg;
    logic          zero_divisor_reg, saturated_reg;

    always_comb
    begin
        tail = chain_ctrl[W];
        case (tail.cmd)
            CMD_DIV:
            begin
                mag_re = tail.zdiv ? '0 : RW'(chain_q_re[W]);
                mag_im = tail.zdiv ? '0 : RW'(chain_q_im[W]);
            end
            CMD_MUL:
            begin
                mag_re = chain_rem_re[W] >> F;
                mag_im = chain_rem_im[W] >> F;
            end
            CMD_MAG:
            begin
                mag_re = RW'(chain_q_re[W]);
                mag_im = '0;
            end
            default:
            begin
                mag_re = chain_rem_re[W];
                mag_im = chain_rem_im[W];
            end
        endcase

        sat_re = (tail.cmd == CMD_DIV && !tail.zdiv && tail.ovf_re)
               || (tail.re_neg ? (mag_re > HALF) : (mag_re >= HALF));
        sat_im = (tail.cmd == CMD_DIV && !tail.zdiv && tail.ovf_im)
               || (tail.im_neg ? (mag_im > HALF) : (mag_im >= HALF));

        if (sat_re)
            val_re = tail.re_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            val_re = tail.re_neg ? (~mag_re[W-1:0] + 1'b1) : mag_re[W-1:0];
        if (sat_im)
            val_im = tail.im_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            val_im = tail.im_neg ? (~mag_im[W-1:0] + 1'b1) : mag_im[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= tail.valid;
    end

    always_ff @(posedge clk)
    begin
        result_real_reg  <= val_re;
        result_imag_reg  <= val_im;
        zero_divisor_reg <= tail.zdiv;
        saturated_reg    <= sat_re | sat_im;
    end

    assign busy         = 1'b0;
    assign done         = done_reg;
    assign result_real  = signed'(result_real_reg);
    assign result_imag  = signed'(result_imag_reg);
    assign zero_divisor = zero_divisor_reg;
    assign saturated    = saturated_reg;

    a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("request did not produce a result at the expected latency");

    a_result_had_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching request");

    a_zdiv_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && zero_divisor |-> !saturated && result_real == '0 && result_imag == '0)
        else $error("zero-divisor result not cleared");

endmodule

// File: rtl/cau_front.sv
// Front pipeline: magnitudes, products, signed sums and divider set-up.
`timescale 1ns / 1ps

module cau_front
    import cau_pkg::*;
#(
    parameter int WORD_BITS     = CAU_WORD_BITS,
    parameter int FRACTION_BITS = CAU_FRACTION_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [2:0]                    command,
    input  logic signed [WORD_BITS-1:0]   first_real,
    input  logic signed [WORD_BITS-1:0]   first_imag,
    input  logic signed [WORD_BITS-1:0]   second_real,
    input  logic signed [WORD_BITS-1:0]   second_imag,
    output ctrl_t                         ctrl,
    output logic [3*WORD_BITS+1:0]        rem_re,
    output logic [3*WORD_BITS+1:0]        rem_im,
    output logic [2*WORD_BITS:0]          den
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int RW = 3 * W + 2;
    localparam int DW = 2 * W + 1;
    localparam logic signed [W:0] ONE = {{(W - F){1'b0}}, 1'b1, {F{1'b0}}};

    // stage 1: captured request
    logic                s1_valid_reg;
    cmd_t                s1_cmd_reg;
    logic signed [W-1:0] s1_a_reg, s1_b_reg, s1_c_reg, s1_d_reg;

    // stage 2: products and simple results
    logic                s2_valid_reg;
    cmd_t                s2_cmd_reg;
    logic                s2_n_ac_reg, s2_n_bd_reg, s2_n_ad_reg, s2_n_bc_reg;
    logic [2*W-1:0]      s2_p1_reg, s2_p2_reg, s2_p3_reg, s2_p4_reg, s2_p5_reg, s2_p6_reg;
    logic signed [W:0]   s2_sr_reg, s2_si_reg;

    // stage 3: signed sums
    logic                  s3_valid_reg;
    cmd_t                  s3_cmd_reg;
    logic signed [2*W+1:0] s3_re_reg, s3_im_reg;
    logic [DW-1:0]         s3_den_reg;

    // stage 4: sign and magnitude
    logic          s4_valid_reg;
    cmd_t          s4_cmd_reg;
    logic          s4_re_neg_reg, s4_im_neg_reg, s4_zdiv_reg;
    logic [DW-1:0] s4_re_reg, s4_im_reg, s4_den_reg;

    logic [W-1:0]        ma, mb, mc, md, sq_x, sq_y;
    logic signed [W:0]   ax, bx, cx, dx, sr_next, si_next;
    logic signed [2*W+1:0] t_ac, t_bd, t_ad, t_bc, re_next, im_next;
    logic [2*W+1:0]      abs_re, abs_im;
    logic [DW-1:0]       mre_next, mim_next;
    logic                rneg_next, ineg_next;
    logic [RW-1:0]       num_re, num_im, den_w;

    // stage 1 -> 2
    always_comb
    begin
        ma = s1_a_reg[W-1] ? (~s1_a_reg + 1'b1) : s1_a_reg;
        mb = s1_b_reg[W-1] ? (~s1_b_reg + 1'b1) : s1_b_reg;
        mc = s1_c_reg[W-1] ? (~s1_c_reg + 1'b1) : s1_c_reg;
        md = s1_d_reg[W-1] ? (~s1_d_reg + 1'b1) : s1_d_reg;
        sq_x = (s1_cmd_reg == CMD_MAG) ? ma : mc;
        sq_y = (s1_cmd_reg == CMD_MAG) ? mb : md;
        ax = {s1_a_reg[W-1], s1_a_reg};
        bx = {s1_b_reg[W-1], s1_b_reg};
        cx = {s1_c_reg[W-1], s1_c_reg};
        dx = {s1_d_reg[W-1], s1_d_reg};
        case (s1_cmd_reg)
            CMD_ADD: begin sr_next = ax + cx;  si_next = bx + dx; end
            CMD_SUB: begin sr_next = ax - cx;  si_next = bx - dx; end
            CMD_NEG: begin sr_next = -ax;      si_next = -bx;     end
            CMD_INC: begin sr_next = ax + ONE; si_next = bx;      end
            CMD_DEC: begin sr_next = ax - ONE; si_next = bx;      end
            default: begin sr_next = '0;       si_next = '0;      end
        endcase
    end

    // stage 2 -> 3
    always_comb
    begin
        t_ac = s2_n_ac_reg ? -signed'({2'b00, s2_p1_reg}) : signed'({2'b00, s2_p1_reg});
        t_bd = s2_n_bd_reg ? -signed'({2'b00, s2_p2_reg}) : signed'({2'b00, s2_p2_reg});
        t_ad = s2_n_ad_reg ? -signed'({2'b00, s2_p3_reg}) : signed'({2'b00, s2_p3_reg});
        t_bc = s2_n_bc_reg ? -signed'({2'b00, s2_p4_reg}) : signed'({2'b00, s2_p4_reg});
        case (s2_cmd_reg)
            CMD_MUL: begin re_next = t_ac - t_bd; im_next = t_ad + t_bc; end
            CMD_DIV: begin re_next = t_ac + t_bd; im_next = t_bc - t_ad; end
            default:
            begin
                re_next = (2*W+2)'(s2_sr_reg);
                im_next = (2*W+2)'(s2_si_reg);
            end
        endcase
    end

    // stage 3 -> 4
    always_comb
    begin
        abs_re = s3_re_reg[2*W+1] ? (2*W+2)'(-s3_re_reg) : (2*W+2)'(s3_re_reg);
        abs_im = s3_im_reg[2*W+1] ? (2*W+2)'(-s3_im_reg) : (2*W+2)'(s3_im_reg);
        if (s3_cmd_reg == CMD_MAG)
        begin
            mre_next  = s3_den_reg;
            mim_next  = '0;
            rneg_next = 1'b0;
            ineg_next = 1'b0;
        end
        else
        begin
            mre_next  = abs_re[DW-1:0];
            mim_next  = abs_im[DW-1:0];
            rneg_next = s3_re_reg[2*W+1];
            ineg_next = s3_im_reg[2*W+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg <= cmd_t'(command);
        s1_a_reg   <= first_real;
        s1_b_reg   <= first_imag;
        s1_c_reg   <= second_real;
        s1_d_reg   <= second_imag;

        s2_cmd_reg  <= s1_cmd_reg;
        s2_n_ac_reg <= s1_a_reg[W-1] ^ s1_c_reg[W-1];
        s2_n_bd_reg <= s1_b_reg[W-1] ^ s1_d_reg[W-1];
        s2_n_ad_reg <= s1_a_reg[W-1] ^ s1_d_reg[W-1];
        s2_n_bc_reg <= s1_b_reg[W-1] ^ s1_c_reg[W-1];
        s2_p1_reg   <= ma * mc;
        s2_p2_reg   <= mb * md;
        s2_p3_reg   <= ma * md;
        s2_p4_reg   <= mb * mc;
        s2_p5_reg   <= sq_x * sq_x;
        s2_p6_reg   <= sq_y * sq_y;
        s2_sr_reg   <= sr_next;
        s2_si_reg   <= si_next;

        s3_cmd_reg <= s2_cmd_reg;
        s3_re_reg  <= re_next;
        s3_im_reg  <= im_next;
        s3_den_reg <= {1'b0, s2_p5_reg} + {1'b0, s2_p6_reg};

        s4_cmd_reg    <= s3_cmd_reg;
        s4_re_neg_reg <= rneg_next;
        s4_im_neg_reg <= ineg_next;
        s4_zdiv_reg   <= (s3_cmd_reg == CMD_DIV) && (s3_den_reg == '0);
        s4_re_reg     <= mre_next;
        s4_im_reg     <= mim_next;
        s4_den_reg    <= s3_den_reg;
    end

    // divider set-up: dividend scaled by the fraction, quotient range check; other commands pass through unscaled
    always_comb
    begin
        num_re = RW'(s4_re_reg) << F;
        num_im = RW'(s4_im_reg) << F;
        den_w  = RW'(s4_den_reg) << W;
        ctrl.valid  = s4_valid_reg;
        ctrl.cmd    = s4_cmd_reg;
        ctrl.re_neg = s4_re_neg_reg;
        ctrl.im_neg = s4_im_neg_reg;
        ctrl.zdiv   = s4_zdiv_reg;
        if (s4_cmd_reg == CMD_DIV)
        begin
            rem_re      = num_re;
            rem_im      = num_im;
            ctrl.ovf_re = num_re >= den_w;
            ctrl.ovf_im = num_im >= den_w;
        end
        else
        begin
            rem_re      = RW'(s4_re_reg);
            rem_im      = RW'(s4_im_reg);
            ctrl.ovf_re = 1'b0;
            ctrl.ovf_im = 1'b0;
        end
        den = s4_den_reg;
    end

endmodule

// File: rtl/cau_cell.sv
// One cell of the divide / square-root chain: resolves one result bit.
`timescale 1ns / 1ps

module cau_cell
    import cau_pkg::*;
#(
    parameter int WORD_BITS = CAU_WORD_BITS,
    parameter int STEP      = 0
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_t                  ctrl_i,
    input  logic [3*WORD_BITS+1:0] rem_re_i,
    input  logic [3*WORD_BITS+1:0] rem_im_i,
    input  logic [2*WORD_BITS:0]   den_i,
    input  logic [WORD_BITS-1:0]   q_re_i,
    input  logic [WORD_BITS-1:0]   q_im_i,
    output ctrl_t                  ctrl_o,
    output logic [3*WORD_BITS+1:0] rem_re_o,
    output logic [3*WORD_BITS+1:0] rem_im_o,
    output logic [2*WORD_BITS:0]   den_o,
    output logic [WORD_BITS-1:0]   q_re_o,
    output logic [WORD_BITS-1:0]   q_im_o
);

    localparam int W  = WORD_BITS;
    localparam int RW = 3 * W + 2;
    localparam int DW = 2 * W + 1;

    ctrl_t         ctrl_reg;
    logic [RW-1:0] rem_re_reg, rem_im_reg, rem_re_next, rem_im_next;
    logic [DW-1:0] den_reg;
    logic [W-1:0]  q_re_reg, q_im_reg, q_re_next, q_im_next;
    logic [RW-1:0] tr_re, tr_im;
    logic          take_re, take_im;

    always_comb
    begin
        // square root: (2r + 2^k) * 2^k added to r^2 when this bit is set
        if (ctrl_i.cmd == CMD_MAG)
            tr_re = (RW'(q_re_i) << (STEP + 1)) | (RW'(1) << (2 * STEP));
        else
            tr_re = RW'(den_i) << STEP;
        tr_im   = RW'(den_i) << STEP;
        take_re = ((ctrl_i.cmd == CMD_DIV) || (ctrl_i.cmd == CMD_MAG)) && (rem_re_i >= tr_re);
        take_im = (ctrl_i.cmd == CMD_DIV) && (rem_im_i >= tr_im);
        rem_re_next = take_re ? (rem_re_i - tr_re) : rem_re_i;
        rem_im_next = take_im ? (rem_im_i - tr_im) : rem_im_i;
        q_re_next   = q_re_i | (take_re ? (W'(1) << STEP) : '0);
        q_im_next   = q_im_i | (take_im ? (W'(1) << STEP) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else
            ctrl_reg <= ctrl_i;
    end

    always_ff @(posedge clk)
    begin
        rem_re_reg <= rem_re_next;
        rem_im_reg <= rem_im_next;
        den_reg    <= den_i;
        q_re_reg   <= q_re_next;
        q_im_reg   <= q_im_next;
    end

    assign ctrl_o   = ctrl_reg;
    assign rem_re_o = rem_re_reg;
    assign rem_im_o = rem_im_reg;
    assign den_o    = den_reg;
    assign q_re_o   = q_re_reg;
    assign q_im_o   = q_im_reg;

endmodule
